[design/stq_pkg.sv]
// ----------------------------------------------------------------------------
// stq_pkg
// Shared constants, codes, command/status types and time helpers for the
// software timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TIME_BITS  = 32;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int WIN_W      = 16;

  localparam logic [WIN_W-1:0] WIN_RESET = 16'd5;

  localparam logic [2:0] MODE_SETUP   = 3'd0;
  localparam logic [2:0] MODE_START   = 3'd1;
  localparam logic [2:0] MODE_STOP    = 3'd2;
  localparam logic [2:0] MODE_TICK    = 3'd3;
  localparam logic [2:0] MODE_SERVICE = 3'd4;
  localparam logic [2:0] MODE_CLEAR   = 3'd5;

  localparam logic [1:0] KIND_FIRE     = 2'd0;
  localparam logic [1:0] KIND_DEFERRED = 2'd1;
  localparam logic [1:0] KIND_STATUS   = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic remove;
    logic setup;
    logic start;
    logic tick_start;
    logic tick_pop;
    logic tick_post;
    logic scan_step;
    logic insert;
    logic svc_emit;
    logic svc_done;
    logic clear_all;
    logic emit_fire;
    logic emit_status;
  } stq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] mode;
    logic       running;
    logic       repeat_on;
    logic       defer_on;
    logic       tick_go;
    logic       tick_more;
    logic       scan_hit;
    logic       svc_more;
    logic       out_free;
  } stq_stat_t;

  // Wrap-aware compare: a is strictly later than b
  function automatic logic later(input logic [TIME_BITS-1:0] a,
                                 input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_BITS-1];
  endfunction

endpackage

`default_nettype wire

[design/stq_if.sv]
// ----------------------------------------------------------------------------
// stq_if
// Request and result channels of the software timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface stq_req_if import stq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           mode;
  logic [IDX_W-1:0]     timer_index;
  logic [TIME_BITS-1:0] period_ms;
  logic                 repeat_flag;
  logic                 defer_flag;
  logic [TIME_BITS-1:0] now_ms;

  modport source (output valid, mode, timer_index, period_ms, repeat_flag, defer_flag,
                  now_ms, input ready);
  modport sink (input valid, mode, timer_index, period_ms, repeat_flag, defer_flag,
                now_ms, output ready);
endinterface

interface stq_rsp_if import stq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           event_kind;
  logic [IDX_W-1:0]     fired_index;
  logic                 wakeup_armed;
  logic [TIME_BITS-1:0] wakeup_time;
  logic                 last;

  modport source (output valid, event_kind, fired_index, wakeup_armed, wakeup_time, last,
                  input ready);
  modport sink (input valid, event_kind, fired_index, wakeup_armed, wakeup_time, last,
                output ready);
endinterface

`default_nettype wire

[design/stq_datapath.sv]
// ----------------------------------------------------------------------------
// stq_datapath
// Timer table, sorted run queue with deadlines, deferred FIFO and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_datapath import stq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [WIN_W-1:0]     cfg_wdata,
  input  logic [2:0]           in_mode,
  input  logic [IDX_W-1:0]     in_index,
  input  logic [TIME_BITS-1:0] in_period,
  input  logic                 in_repeat,
  input  logic                 in_defer,
  input  logic [TIME_BITS-1:0] in_now,
  input  stq_cmd_t             cmd,
  output stq_stat_t            stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [IDX_W-1:0]     out_index,
  output logic                 out_armed,
  output logic [TIME_BITS-1:0] out_time,
  output logic                 out_last
);

  localparam logic [NUM_TIMERS-1:0] ONES = '1;

  logic [WIN_W-1:0]     window;
  logic [TIME_BITS-1:0] period [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] rep, dfr, running, pending, fired;
  logic [IDX_W-1:0]     run_order [NUM_TIMERS];
  logic [TIME_BITS-1:0] run_dl [NUM_TIMERS];
  logic [CNT_W-1:0]     run_count;
  logic [IDX_W-1:0]     fifo [NUM_TIMERS];
  logic [CNT_W-1:0]     defer_count;

  logic [2:0]           mode;
  logic [IDX_W-1:0]     cur;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] thr;
  logic [TIME_BITS-1:0] set_period;
  logic                 set_rep, set_dfr;
  logic [TIME_BITS-1:0] cand;
  logic [CNT_W-1:0]     scan_k;
  logic [CNT_W-1:0]     svc_k;

  logic [NUM_TIMERS-1:0] run_hit, run_shift, fifo_hit, fifo_shift;
  logic [IDX_W-1:0]      head;
  logic [TIME_BITS-1:0]  head_dl;
  logic [IDX_W-1:0]      svc_slot;

  assign head     = run_order[0];
  assign head_dl  = run_dl[0];
  assign svc_slot = fifo[svc_k[IDX_W-1:0]];

  // Match vectors and shift masks for removal from the middle of a queue
  always_comb begin
    for (int j = 0; j < NUM_TIMERS; j++) begin
      if (cmd.tick_pop) begin
        run_hit[j] = (j == 0);
      end else begin
        run_hit[j] = (CNT_W'(j) < run_count) && (run_order[j] == cur);
      end
      fifo_hit[j] = (CNT_W'(j) < defer_count) && (fifo[j] == cur);
    end
    for (int j = 0; j < NUM_TIMERS; j++) begin
      run_shift[j]  = |(run_hit & (ONES >> (NUM_TIMERS - 1 - j)));
      fifo_shift[j] = |(fifo_hit & (ONES >> (NUM_TIMERS - 1 - j)));
    end
  end

  always_comb begin
    stat.mode      = mode;
    stat.running   = running[cur];
    stat.repeat_on = rep[cur];
    stat.defer_on  = dfr[cur];
    stat.tick_go   = (run_count != '0) && !later(head_dl, now);
    stat.tick_more = (run_count != '0) && !fired[head] && later(thr, head_dl);
    stat.scan_hit  = (scan_k == run_count) || later(run_dl[scan_k[IDX_W-1:0]], cand);
    stat.svc_more  = svc_k < defer_count;
    stat.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window      <= WIN_RESET;
      rep         <= '0;
      dfr         <= '0;
      running     <= '0;
      pending     <= '0;
      fired       <= '0;
      run_count   <= '0;
      defer_count <= '0;
      out_valid   <= 1'b0;
      for (int j = 0; j < NUM_TIMERS; j++) begin
        period[j] <= '0;
      end
    end else begin
      if (cfg_we) begin
        window <= cfg_wdata;
      end

      if (cmd.latch) begin
        mode       <= in_mode;
        cur        <= in_index;
        now        <= in_now;
        thr        <= in_now + TIME_BITS'(window);
        set_period <= in_period;
        set_rep    <= in_repeat;
        set_dfr    <= in_defer;
        svc_k      <= '0;
      end

      // Drop the named timer from both queues
      if (cmd.remove) begin
        running[cur] <= 1'b0;
        pending[cur] <= 1'b0;
        if (|run_hit) begin
          for (int j = 0; j < NUM_TIMERS - 1; j++) begin
            if (run_shift[j]) begin
              run_order[j] <= run_order[j+1];
              run_dl[j]    <= run_dl[j+1];
            end
          end
          run_count <= run_count - 1'b1;
        end
        if (|fifo_hit) begin
          for (int j = 0; j < NUM_TIMERS - 1; j++) begin
            if (fifo_shift[j]) begin
              fifo[j] <= fifo[j+1];
            end
          end
          defer_count <= defer_count - 1'b1;
        end
      end

      if (cmd.setup) begin
        period[cur] <= set_period;
        rep[cur]    <= set_rep;
        dfr[cur]    <= set_dfr;
      end

      if (cmd.start) begin
        cand   <= now + period[cur];
        scan_k <= '0;
      end

      if (cmd.tick_start) begin
        fired <= '0;
      end

      // Pop the head timer
      if (cmd.tick_pop) begin
        cur           <= head;
        cand          <= head_dl;
        fired[head]   <= 1'b1;
        running[head] <= 1'b0;
        scan_k        <= '0;
        for (int j = 0; j < NUM_TIMERS - 1; j++) begin
          run_order[j] <= run_order[j+1];
          run_dl[j]    <= run_dl[j+1];
        end
        run_count <= run_count - 1'b1;
      end

      if (cmd.tick_post) begin
        if (rep[cur]) begin
          cand <= cand + period[cur];
        end
        if (dfr[cur] && !pending[cur] && (defer_count < CNT_W'(NUM_TIMERS))) begin
          fifo[defer_count[IDX_W-1:0]] <= cur;
          pending[cur] <= 1'b1;
          defer_count  <= defer_count + 1'b1;
        end
      end

      if (cmd.scan_step) begin
        scan_k <= scan_k + 1'b1;
      end

      // Place the candidate at the scan position, shifting later entries up
      if (cmd.insert) begin
        for (int j = 0; j < NUM_TIMERS; j++) begin
          if (CNT_W'(j) == scan_k) begin
            run_order[j] <= cur;
            run_dl[j]    <= cand;
          end else if ((j > 0) && (CNT_W'(j) > scan_k)) begin
            run_order[j] <= run_order[j-1];
            run_dl[j]    <= run_dl[j-1];
          end
        end
        run_count    <= run_count + 1'b1;
        running[cur] <= 1'b1;
      end

      if (cmd.svc_emit) begin
        pending[svc_slot] <= 1'b0;
        svc_k             <= svc_k + 1'b1;
      end

      if (cmd.svc_done) begin
        defer_count <= '0;
      end

      if (cmd.clear_all) begin
        running     <= '0;
        pending     <= '0;
        run_count   <= '0;
        defer_count <= '0;
      end

      if (cmd.emit_fire) begin
        out_valid <= 1'b1;
        out_kind  <= KIND_FIRE;
        out_index <= cur;
        out_armed <= 1'b0;
        out_time  <= '0;
        out_last  <= 1'b0;
      end else if (cmd.svc_emit) begin
        out_valid <= 1'b1;
        out_kind  <= KIND_DEFERRED;
        out_index <= svc_slot;
        out_armed <= 1'b0;
        out_time  <= '0;
        out_last  <= 1'b0;
      end else if (cmd.emit_status) begin
        out_valid <= 1'b1;
        out_kind  <= KIND_STATUS;
        out_index <= '0;
        out_armed <= (run_count != '0);
        out_time  <= (run_count != '0) ? head_dl : '0;
        out_last  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run_count <= CNT_W'(NUM_TIMERS))
    else $error("run queue over capacity");

  a_run_flags: assert property (@(posedge clk) disable iff (rst)
    $countones(running) == int'(run_count))
    else $error("running flags disagree with run queue length");

  // The drain clears pending flags one by one before the FIFO length drops
  a_pend_flags: assert property (@(posedge clk) disable iff (rst)
    $countones(pending) <= int'(defer_count))
    else $error("pending flags exceed deferred FIFO length");

endmodule

`default_nettype wire

[design/stq_ctrl.sv]
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer for the software timer queue: decodes a request and walks the
// insert scan, the firing loop and the deferred drain.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_ctrl import stq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  stq_stat_t stat,
  output stq_cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE, DECODE, SCAN, TICK, POST, FIRE, SERVICE, STATUS
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = DECODE;
        end
      end
      DECODE: begin
        unique case (stat.mode)
          MODE_SETUP: begin
            cmd.remove = 1'b1;
            cmd.setup  = 1'b1;
            state_next = STATUS;
          end
          MODE_START: begin
            if (!stat.running) begin
              cmd.start  = 1'b1;
              state_next = SCAN;
            end else begin
              state_next = STATUS;
            end
          end
          MODE_STOP: begin
            cmd.remove = 1'b1;
            state_next = STATUS;
          end
          MODE_TICK: begin
            if (stat.tick_go) begin
              cmd.tick_start = 1'b1;
              state_next     = TICK;
            end else begin
              state_next = STATUS;
            end
          end
          MODE_SERVICE: state_next = SERVICE;
          MODE_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_next    = STATUS;
          end
          default: state_next = STATUS;
        endcase
      end
      SCAN: begin
        if (stat.scan_hit) begin
          cmd.insert = 1'b1;
          state_next = (stat.mode == MODE_TICK) ? FIRE : STATUS;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      TICK: begin
        if (stat.tick_more) begin
          cmd.tick_pop = 1'b1;
          state_next   = POST;
        end else begin
          state_next = STATUS;
        end
      end
      POST: begin
        cmd.tick_post = 1'b1;
        state_next    = stat.repeat_on ? SCAN : FIRE;
      end
      FIRE: begin
        if (stat.defer_on) begin
          state_next = TICK;
        end else if (stat.out_free) begin
          cmd.emit_fire = 1'b1;
          state_next    = TICK;
        end
      end
      SERVICE: begin
        if (stat.svc_more) begin
          if (stat.out_free) begin
            cmd.svc_emit = 1'b1;
          end
        end else begin
          cmd.svc_done = 1'b1;
          state_next   = STATUS;
        end
      end
      STATUS: begin
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[design/software_timer_queue.sv]
// ----------------------------------------------------------------------------
// software_timer_queue
// Sorted timer queue with deadline coalescing and deferred service.
// ----------------------------------------------------------------------------
// Usage: a request on req carries a mode (set up, start, stop, tick, service
// deferred, clear all) and its operands. Every request produces one or more
// results on rsp; the final one is a wakeup status with last set. Tick
// requests emit one fire result per non-deferred timer that fires; service
// requests emit one result per deferred entry, in FIFO order.
// cfg_we/cfg_wdata load the coalescing window (reset 5); the user must write
// it only while idle, as the block does not enforce this. Set up, stop and
// clear go from decode straight to the status. A start scans the run queue
// one entry per cycle and inserts the timer ahead of the first later
// deadline. A tick pops each due timer, re-inserts each repeat timer by its
// own insert scan and emits a fire result per non-deferred timer. A service
// emits one result per deferred entry, then the status.
// A new request is accepted once the status is in the result register.
// Reset empties both queues, idles all timers and zeroes periods and marks.
// A stall on rsp holds the result register and pauses the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module software_timer_queue import stq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [WIN_W-1:0] cfg_wdata,
  stq_req_if.sink          req,
  stq_rsp_if.source        rsp
);

  stq_cmd_t  cmd;
  stq_stat_t stat;

  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_mode   (req.mode),
    .in_index  (req.timer_index),
    .in_period (req.period_ms),
    .in_repeat (req.repeat_flag),
    .in_defer  (req.defer_flag),
    .in_now    (req.now_ms),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_kind  (rsp.event_kind),
    .out_index (rsp.fired_index),
    .out_armed (rsp.wakeup_armed),
    .out_time  (rsp.wakeup_time),
    .out_last  (rsp.last)
  );

endmodule

`default_nettype wire
